@@ rtl/core/qhtc_pkg.sv @@
`timescale 1ns / 1ps

package qhtc_pkg;

  localparam int QUAL_W  = 7;
  localparam int CNT_W   = 32;
  localparam int TOTAL_W = 48;

  localparam logic [1:0] CMD_SAMPLE   = 2'd0;
  localparam logic [1:0] CMD_BOUNDARY = 2'd1;
  localparam logic [1:0] CMD_END      = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_FINAL  = 2'd1;
  localparam logic [1:0] KIND_BIN    = 2'd2;

  localparam logic REG_THRESHOLD = 1'b0;

  typedef struct packed {
    logic [1:0]        command;
    logic [QUAL_W-1:0] quality;
    logic [QUAL_W-1:0] bin_index;
  } item_t;

  typedef struct packed {
    logic [1:0]         report_kind;
    logic [CNT_W-1:0]   record_number;
    logic [CNT_W-1:0]   record_count;
    logic [TOTAL_W-1:0] total_count;
    logic [CNT_W-1:0]   bin_count;
    logic [QUAL_W-1:0]  max_quality;
  } result_t;

  function automatic logic [CNT_W-1:0] inc_sat32(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [TOTAL_W-1:0] add_sat48(input logic [TOTAL_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {{(TOTAL_W + 1 - CNT_W){1'b0}}, b};
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

endpackage

@@ rtl/core/qhtc_if.sv @@
`timescale 1ns / 1ps

interface qhtc_in_if
  import qhtc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [QUAL_W-1:0] quality;
  logic [QUAL_W-1:0] bin_index;

  modport source (output valid, command, quality, bin_index, input ready);
  modport sink (input valid, command, quality, bin_index, output ready);
endinterface

interface qhtc_out_if
  import qhtc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [1:0]         report_kind;
  logic [CNT_W-1:0]   record_number;
  logic [CNT_W-1:0]   record_count;
  logic [TOTAL_W-1:0] total_count;
  logic [CNT_W-1:0]   bin_count;
  logic [QUAL_W-1:0]  max_quality;

  modport source (output valid, report_kind, record_number, record_count, total_count,
                  bin_count, max_quality, input ready);
  modport sink (input valid, report_kind, record_number, record_count, total_count,
                bin_count, max_quality, output ready);
endinterface

@@ rtl/core/qhtc_cfg.sv @@
`timescale 1ns / 1ps

module qhtc_cfg
  import qhtc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [QUAL_W-1:0] threshold
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (wr_en && paddr[2] == REG_THRESHOLD) begin
      threshold <= pwdata[QUAL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_THRESHOLD) begin
      prdata = {{(32 - QUAL_W){1'b0}}, threshold};
    end
  end

endmodule

@@ rtl/core/qhtc_hist.sv @@
`timescale 1ns / 1ps

module qhtc_hist
  import qhtc_pkg::*;
#(
  parameter int NUM_BINS = 128
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(NUM_BINS)-1:0]  rd_addr,
  input  logic                         inc_en,
  output logic [CNT_W-1:0]             cur_count,
  output logic                         busy
);

  localparam int AW = $clog2(NUM_BINS);

  logic [CNT_W-1:0] mem [NUM_BINS];
  logic [CNT_W-1:0] rd_data;
  logic [AW-1:0]    rd_addr_q;
  logic             fwd_en;
  logic [AW-1:0]    fwd_addr;
  logic [CNT_W-1:0] fwd_data;
  logic [AW-1:0]    clr_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [CNT_W-1:0] wr_data;
  logic [CNT_W-1:0] inc_data;

  // The write that lands on the same edge as the read is not seen by the
  // memory output, so it is held aside and merged here.
  assign cur_count = (fwd_en && fwd_addr == rd_addr_q) ? fwd_data : rd_data;
  assign inc_data  = inc_sat32(cur_count);

  assign wr_en   = busy || inc_en;
  assign wr_addr = busy ? clr_addr : rd_addr_q;
  assign wr_data = busy ? '0 : inc_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_addr_q <= rd_addr;
      fwd_addr  <= rd_addr_q;
      fwd_data  <= inc_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
      fwd_en   <= 1'b0;
    end else begin
      if (busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(NUM_BINS - 1)) begin
          busy <= 1'b0;
        end
      end
      if (rd_en) begin
        fwd_en <= inc_en;
      end
    end
  end

endmodule

@@ rtl/core/qhtc_eval.sv @@
`timescale 1ns / 1ps

module qhtc_eval
  import qhtc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  item_t             item,
  input  logic              in_range,
  input  logic [CNT_W-1:0]  bin_cur,
  input  logic [QUAL_W-1:0] threshold,
  output logic              has_res,
  output result_t           res
);

  logic [CNT_W-1:0]   record_counter, record_counter_next;
  logic [CNT_W-1:0]   current_above, current_above_next;
  logic [TOTAL_W-1:0] total_above, total_above_next;
  logic [QUAL_W-1:0]  max_seen, max_seen_next;
  logic [TOTAL_W-1:0] total_sum;

  assign total_sum = add_sat48(total_above, current_above);

  always_comb begin
    record_counter_next = record_counter;
    current_above_next  = current_above;
    total_above_next    = total_above;
    max_seen_next       = max_seen;
    has_res             = 1'b0;
    res                 = '0;
    res.max_quality     = max_seen;
    case (item.command)
      CMD_SAMPLE: begin
        if (item.quality > max_seen) begin
          max_seen_next = item.quality;
        end
        if (item.quality >= threshold) begin
          current_above_next = inc_sat32(current_above);
        end
      end
      CMD_BOUNDARY: begin
        // The boundary that opens the first record has nothing to report.
        has_res             = (record_counter != '0);
        res.report_kind     = KIND_RECORD;
        res.record_number   = record_counter;
        res.record_count    = current_above;
        record_counter_next = inc_sat32(record_counter);
        total_above_next    = total_sum;
        current_above_next  = '0;
      end
      CMD_END: begin
        has_res            = 1'b1;
        res.report_kind    = KIND_FINAL;
        res.record_number  = record_counter;
        res.record_count   = current_above;
        res.total_count    = total_sum;
        total_above_next   = total_sum;
        current_above_next = '0;
      end
      default: begin
        has_res         = 1'b1;
        res.report_kind = KIND_BIN;
        res.bin_count   = in_range ? bin_cur : '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_counter <= '0;
      current_above  <= '0;
      total_above    <= '0;
      max_seen       <= '0;
    end else if (step) begin
      record_counter <= record_counter_next;
      current_above  <= current_above_next;
      total_above    <= total_above_next;
      max_seen       <= max_seen_next;
    end
  end

endmodule

@@ rtl/core/quality_histogram_threshold_counter_top.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Payload                                              Handshake
// samples   in   command, quality, bin_index                          valid/ready
// reports   out  report_kind, record_number, record_count,            valid/ready
//                total_count, bin_count, max_quality
// apb       in   threshold register at byte address 0                 psel/penable
//
// One item per cycle is accepted unless the histogram is being cleared or a
// stalled result holds the item register. The item register is loaded with
// the histogram memory read when an item is accepted; the output register
// then takes the count update, with forwarding from the previous item's
// write. After reset the histogram is cleared one bin a cycle, and samples
// are not accepted until every bin is cleared. A stalled result holds the
// update stage; samples, which give no result, still drain past it.

module quality_histogram_threshold_counter_top
  import qhtc_pkg::*;
#(
  parameter int NUM_BINS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  qhtc_in_if.sink     samples,
  qhtc_out_if.source  reports
);

  localparam int AW = $clog2(NUM_BINS);

  logic              in_accept;
  logic              busy;
  logic [QUAL_W-1:0] threshold;
  logic [QUAL_W-1:0] addr_in;
  logic              range_in;
  item_t             s1_item;
  logic              s1_valid;
  logic              s1_in_range;
  logic              s1_adv;
  logic              s1_has_res;
  result_t           s1_res;
  logic [CNT_W-1:0]  bin_cur;
  logic              out_valid;
  result_t           out_res;

  qhtc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .threshold (threshold)
  );

  assign addr_in  = (samples.command == CMD_READ) ? samples.bin_index : samples.quality;
  assign range_in = ({{(32 - QUAL_W){1'b0}}, addr_in} < 32'(NUM_BINS));

  assign s1_adv    = s1_valid && (!s1_has_res || !out_valid || reports.ready);
  assign samples.ready = !busy && (!s1_valid || s1_adv);
  assign in_accept = samples.valid && samples.ready;

  qhtc_hist #(
    .NUM_BINS (NUM_BINS)
  ) u_hist (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_accept),
    .rd_addr   (AW'(addr_in)),
    .inc_en    (s1_adv && s1_item.command == CMD_SAMPLE && s1_in_range),
    .cur_count (bin_cur),
    .busy      (busy)
  );

  qhtc_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_adv),
    .item      (s1_item),
    .in_range  (s1_in_range),
    .bin_cur   (bin_cur),
    .threshold (threshold),
    .has_res   (s1_has_res),
    .res       (s1_res)
  );

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.command   <= samples.command;
      s1_item.quality   <= samples.quality;
      s1_item.bin_index <= samples.bin_index;
      s1_in_range       <= range_in;
    end
    if (s1_adv && s1_has_res) begin
      out_res <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && s1_has_res) begin
        out_valid <= 1'b1;
      end else if (reports.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign reports.valid         = out_valid;
  assign reports.report_kind   = out_res.report_kind;
  assign reports.record_number = out_res.record_number;
  assign reports.record_count  = out_res.record_count;
  assign reports.total_count   = out_res.total_count;
  assign reports.bin_count     = out_res.bin_count;
  assign reports.max_quality   = out_res.max_quality;

endmodule

@@ tb/quality_histogram_threshold_counter_top_test.sv @@
`timescale 1ns / 1ps

module quality_histogram_threshold_counter_top_test
  import qhtc_pkg::*;
;

  localparam int NUM_BINS      = 128;
  localparam int RANDOM_ITEMS  = 800;
  localparam int PHASES        = 4;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;

  // Tracks histogram, record and total counts as the block should, and holds
  // the reports that are owed but not yet seen.
  class histogram_scoreboard;
    logic [CNT_W-1:0]   bin_hits[NUM_BINS];
    logic [CNT_W-1:0]   records_seen;
    logic [CNT_W-1:0]   above_in_record;
    logic [TOTAL_W-1:0] above_total;
    logic [QUAL_W-1:0]  peak_quality;
    logic [QUAL_W-1:0]  threshold;
    result_t            owed_reports[$];
    int unsigned        errors;

    function new();
      foreach (bin_hits[i]) bin_hits[i] = '0;
      records_seen    = '0;
      above_in_record = '0;
      above_total     = '0;
      peak_quality    = '0;
      threshold       = '0;
      errors          = 0;
    endfunction

    function void set_threshold(input logic [QUAL_W-1:0] value);
      threshold = value;
    endfunction

    function void roll_into_total();
      logic [TOTAL_W:0] sum;
      sum = above_in_record;
      sum += above_total;
      above_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    endfunction

    function void note_command(input item_t it);
      result_t r;
      r = '0;
      case (it.command)
        CMD_SAMPLE: begin
          if (it.quality < NUM_BINS) begin
            if (~&bin_hits[it.quality]) bin_hits[it.quality]++;
          end
          if (it.quality > peak_quality) peak_quality = it.quality;
          if (it.quality >= threshold && ~&above_in_record) above_in_record++;
        end
        CMD_BOUNDARY: begin
          // The boundary that opens the first record has nothing to report.
          if (records_seen != 0) begin
            r.report_kind   = KIND_RECORD;
            r.record_number = records_seen;
            r.record_count  = above_in_record;
            r.max_quality   = peak_quality;
            owed_reports.push_back(r);
          end
          if (~&records_seen) records_seen++;
          roll_into_total();
          above_in_record = '0;
        end
        CMD_END: begin
          roll_into_total();
          r.report_kind   = KIND_FINAL;
          r.record_number = records_seen;
          r.record_count  = above_in_record;
          r.total_count   = above_total;
          r.max_quality   = peak_quality;
          owed_reports.push_back(r);
          above_in_record = '0;
        end
        default: begin
          r.report_kind = KIND_BIN;
          if (it.bin_index < NUM_BINS) r.bin_count = bin_hits[it.bin_index];
          r.max_quality = peak_quality;
          owed_reports.push_back(r);
        end
      endcase
    endfunction

    task report_mismatch(input string what);
      errors++;
      $display("%0t: mismatch: %s", $time, what);
    endtask

    task check_report(input result_t got);
      result_t want;
      string   diffs;
      if (owed_reports.size() == 0) begin
        report_mismatch($sformatf("report of kind %0d with none owed", got.report_kind));
        return;
      end
      want  = owed_reports.pop_front();
      diffs = "";
      if (got.report_kind !== want.report_kind)
        diffs = {diffs, $sformatf(" kind %0d/%0d", got.report_kind, want.report_kind)};
      if (got.record_number !== want.record_number)
        diffs = {diffs, $sformatf(" record %0d/%0d", got.record_number, want.record_number)};
      if (got.record_count !== want.record_count)
        diffs = {diffs, $sformatf(" count %0d/%0d", got.record_count, want.record_count)};
      if (got.total_count !== want.total_count)
        diffs = {diffs, $sformatf(" total %0d/%0d", got.total_count, want.total_count)};
      if (got.bin_count !== want.bin_count)
        diffs = {diffs, $sformatf(" bin %0d/%0d", got.bin_count, want.bin_count)};
      if (got.max_quality !== want.max_quality)
        diffs = {diffs, $sformatf(" max %0d/%0d", got.max_quality, want.max_quality)};
      if (diffs != "") report_mismatch({"got/expected:", diffs});
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  qhtc_in_if  samples_ch ();
  qhtc_out_if reports_ch ();

  quality_histogram_threshold_counter_top #(
    .NUM_BINS(NUM_BINS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .samples (samples_ch),
    .reports (reports_ch)
  );

  histogram_scoreboard hist_sb = new();

  int unsigned       cycles = 0;
  int unsigned       rx_hold = 0;
  bit                rx_steady = 1'b0;
  bit                tx_steady = 1'b0;
  logic [QUAL_W-1:0] hot_quality = '0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("quality_histogram_threshold_counter_top_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && samples_ch.valid && samples_ch.ready)
      hist_sb.note_command({samples_ch.command, samples_ch.quality, samples_ch.bin_index});
  end

  always @(posedge clk) begin
    if (!rst && reports_ch.valid && reports_ch.ready)
      hist_sb.check_report({reports_ch.report_kind, reports_ch.record_number,
                            reports_ch.record_count, reports_ch.total_count,
                            reports_ch.bin_count, reports_ch.max_quality});
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Report back-pressure, with stretches where the receiver never stalls.
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) rx_steady = ~rx_steady;
    if (rx_hold != 0) begin
      reports_ch.ready <= 1'b0;
      rx_hold--;
    end else begin
      reports_ch.ready <= 1'b1;
      if (!rx_steady) rx_hold = idle_len();
    end
  end

  task automatic send_command(input item_t it);
    int unsigned gap;
    gap = tx_steady ? 0 : idle_len();
    repeat (gap) begin
      samples_ch.valid <= 1'b0;
      @(negedge clk);
    end
    samples_ch.valid <= 1'b1;
    {samples_ch.command, samples_ch.quality, samples_ch.bin_index} <= it;
    @(posedge clk);
    while (!samples_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds off the sender until every owed report has come, then lets any
  // samples still in the pipeline settle.
  task automatic wait_drained();
    samples_ch.valid <= 1'b0;
    while (hist_sb.owed_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [QUAL_W-1:0] thr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_THRESHOLD, 2'b00};
    pwdata  <= {25'($urandom), thr};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    hist_sb.set_threshold(thr);
    @(negedge clk);
    // The address still selects the threshold, so the read data shows it.
    if (prdata !== 32'(thr))
      hist_sb.report_mismatch($sformatf("threshold read %0d/%0d", prdata, thr));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Samples lean toward one recurring bin and toward the threshold edge, and
  // reads often target that recurring bin so back-to-back updates get read.
  function automatic item_t random_command(input logic [QUAL_W-1:0] thr);
    item_t       it;
    int unsigned r;
    it.quality   = QUAL_W'($urandom);
    it.bin_index = QUAL_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 62) begin
      it.command = CMD_SAMPLE;
      case ($urandom_range(0, 3))
        0: it.quality = hot_quality;
        1: it.quality = thr + QUAL_W'($urandom_range(0, 4)) - QUAL_W'(2);
        default: ;
      endcase
      if ($urandom_range(0, 7) == 0) hot_quality = it.quality;
    end else if (r < 74) begin
      it.command = CMD_BOUNDARY;
    end else if (r < 78) begin
      it.command = CMD_END;
    end else begin
      it.command = CMD_READ;
      if ($urandom_range(0, 1) == 0) it.bin_index = hot_quality;
    end
    return it;
  endfunction

  initial begin
    item_t             opening[20];
    logic [QUAL_W-1:0] phase_thr[PHASES];

    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    samples_ch.valid     = 1'b0;
    samples_ch.command   = CMD_SAMPLE;
    samples_ch.quality   = '0;
    samples_ch.bin_index = '0;
    reports_ch.ready     = 1'b0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Threshold 64 splits the directed samples on both sides of the edge.
    write_threshold(7'd64);
    opening = '{
      {CMD_END,      7'd127, 7'd127},  // final report before anything arrived
      {CMD_BOUNDARY, 7'd0,   7'd0},    // opens the first record, no report
      {CMD_SAMPLE,   7'd0,   7'd127},
      {CMD_SAMPLE,   7'd63,  7'd0},    // just below the threshold
      {CMD_SAMPLE,   7'd64,  7'd0},    // exactly at the threshold counts
      {CMD_SAMPLE,   7'd127, 7'd0},
      {CMD_SAMPLE,   7'd127, 7'd127},  // same bin back to back
      {CMD_READ,     7'd127, 7'd127},  // read right behind the updates
      {CMD_READ,     7'd0,   7'd0},
      {CMD_READ,     7'd127, 7'd64},
      {CMD_BOUNDARY, 7'd127, 7'd127},
      {CMD_SAMPLE,   7'd100, 7'd55},
      {CMD_END,      7'd0,   7'd0},
      {CMD_END,      7'd127, 7'd127},  // repeated end mark adds nothing
      {CMD_SAMPLE,   7'd5,   7'd5},
      {CMD_BOUNDARY, 7'd0,   7'd0},
      {CMD_READ,     7'd0,   7'd63},
      {CMD_SAMPLE,   7'd64,  7'd1},
      {CMD_READ,     7'd0,   7'd64},
      {CMD_READ,     7'd42,  7'd1}     // bin never hit
    };
    foreach (opening[i]) send_command(opening[i]);
    wait_drained();

    phase_thr = '{7'd0, 7'd127, QUAL_W'($urandom_range(1, 126)), 7'd1};
    for (int p = 0; p < PHASES; p++) begin
      write_threshold(phase_thr[p]);
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        if (i % 40 == 0) tx_steady = ($urandom_range(0, 3) == 0);
        if (p == 1 && i == RANDOM_ITEMS / (2 * PHASES)) wait_drained();
        send_command(random_command(phase_thr[p]));
      end
      wait_drained();
    end

    if (hist_sb.errors == 0) begin
      $display("quality_histogram_threshold_counter_top_test: PASS");
    end else begin
      $display("quality_histogram_threshold_counter_top_test: FAIL");
    end
    $finish;
  end

endmodule

@@ quality_histogram_threshold_counter_top.f @@
rtl/core/qhtc_pkg.sv
rtl/core/qhtc_if.sv
rtl/core/qhtc_cfg.sv
rtl/core/qhtc_hist.sv
rtl/core/qhtc_eval.sv
rtl/core/quality_histogram_threshold_counter_top.sv
tb/quality_histogram_threshold_counter_top_test.sv
